@@ sv/wcp_pkg.sv @@
`timescale 1ns / 1ps

package wcp_pkg;

  localparam int unsigned SCREEN_ROWS = 480;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned HALF_ROWS   = SCREEN_ROWS / 2;
  localparam int unsigned FRAC2_W     = 2 * FRAC_BITS;

  localparam int unsigned DIST_W     = 24;
  localparam int unsigned DIR_W      = 18;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned TEX_W      = 11;
  localparam int unsigned POS_W      = 24;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned STEP_W     = 26;
  localparam int unsigned SKIP_W     = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEIGHT_SCALE = 3'd0,
    CFG_TEX_WIDTH    = 3'd1,
    CFG_TEX_HEIGHT   = 3'd2,
    CFG_VIEWER_X     = 3'd3,
    CFG_VIEWER_Y     = 3'd4
  } cfg_reg_e;

endpackage

@@ sv/wcp_tex_col.sv @@
`timescale 1ns / 1ps

module wcp_tex_col (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic        [wcp_pkg::DIST_W-1:0]     dist_i,
  input  logic                                  face_i,
  input  logic signed [wcp_pkg::DIR_W-1:0]      dir_x_i,
  input  logic signed [wcp_pkg::DIR_W-1:0]      dir_y_i,
  input  logic        [wcp_pkg::POS_W-1:0]      viewer_x_i,
  input  logic        [wcp_pkg::POS_W-1:0]      viewer_y_i,
  input  logic        [wcp_pkg::TEX_W-1:0]      tex_width_i,
  output logic                                  valid_o,
  output logic        [wcp_pkg::DIST_W-1:0]     dist_o,
  output logic        [wcp_pkg::COL_W-1:0]      col_o
);

  localparam int unsigned PROD_W = wcp_pkg::DIST_W + wcp_pkg::DIR_W + 1;
  localparam int unsigned MUL_W  = wcp_pkg::FRAC2_W + wcp_pkg::TEX_W;

  logic [3:0] vld_q;

  logic signed [wcp_pkg::DIR_W-1:0]     dir_sel;
  logic signed [PROD_W-1:0]             prod_d, prod1_q;
  logic [wcp_pkg::FRAC_BITS-1:0]        pos_d, pos1_q;
  logic                                 flip_d, flip1_q, flip2_q, flip3_q;
  logic [wcp_pkg::DIST_W-1:0]           dist1_q, dist2_q, dist3_q, dist4_q;
  logic [wcp_pkg::FRAC2_W-1:0]          frac_d, frac2_q;
  logic [MUL_W-1:0]                     scaled_d;
  logic [wcp_pkg::TEX_W-1:0]            colw3_q, mirror_d;
  logic [wcp_pkg::COL_W-1:0]            col_d, col4_q;

  always_comb begin
    dir_sel  = face_i ? dir_x_i : dir_y_i;
    prod_d   = $signed({1'b0, dist_i}) * dir_sel;
    pos_d    = face_i ? viewer_x_i[wcp_pkg::FRAC_BITS-1:0]
                      : viewer_y_i[wcp_pkg::FRAC_BITS-1:0];
    // mirror on west and south faces
    flip_d   = (!face_i && dir_x_i[wcp_pkg::DIR_W-1]) ||
               (face_i && !dir_y_i[wcp_pkg::DIR_W-1] && (dir_y_i != '0));
    frac_d   = {pos1_q, wcp_pkg::FRAC_BITS'(0)} + prod1_q[wcp_pkg::FRAC2_W-1:0];
    scaled_d = MUL_W'(frac2_q) * MUL_W'(tex_width_i);
    mirror_d = tex_width_i - colw3_q - wcp_pkg::TEX_W'(1);
    col_d    = flip3_q ? mirror_d[wcp_pkg::COL_W-1:0] : colw3_q[wcp_pkg::COL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= prod_d;
      pos1_q  <= pos_d;
      flip1_q <= flip_d;
      dist1_q <= dist_i;
      frac2_q <= frac_d;
      flip2_q <= flip1_q;
      dist2_q <= dist1_q;
      colw3_q <= scaled_d[MUL_W-1 -: wcp_pkg::TEX_W];
      flip3_q <= flip2_q;
      dist3_q <= dist2_q;
      col4_q  <= col_d;
      dist4_q <= dist3_q;
    end
  end

  assign valid_o = vld_q[3];
  assign dist_o  = dist4_q;
  assign col_o   = col4_q;

endmodule

@@ sv/wcp_div_pipe.sv @@
`timescale 1ns / 1ps

module wcp_div_pipe #(
  parameter int unsigned NUM_W  = 24,
  parameter int unsigned DEN_W  = 24,
  parameter int unsigned Q_W    = 16,
  parameter int unsigned SIDE_W = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [Q_W:0]        vld_q;
  logic [W-1:0]        rem_q  [Q_W+1];
  logic [DEN_W-1:0]    den_q  [Q_W+1];
  logic [Q_W-1:0]      quo_q  [Q_W+1];
  logic [SIDE_W-1:0]   side_q [Q_W+1];
  logic [Q_W:0]        sat_q;

  logic [W-1:0]        trial  [Q_W];
  logic [Q_W-1:0]      fit;
  logic                sat_d;

  // quotient would not fit in Q_W bits, or divide by zero
  assign sat_d = (den_i == '0) || (W'(num_i) >= (W'(den_i) << Q_W));

  always_comb begin
    for (int s = 0; s < Q_W; s++) begin
      trial[s] = W'(den_q[s]) << (Q_W - 1 - s);
      fit[s]   = rem_q[s] >= trial[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Q_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= W'(num_i);
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
      sat_q[0]  <= sat_d;
      for (int s = 0; s < Q_W; s++) begin
        rem_q[s+1]  <= fit[s] ? rem_q[s] - trial[s] : rem_q[s];
        quo_q[s+1]  <= quo_q[s] | (fit[s] ? (Q_W'(1) << (Q_W - 1 - s)) : '0);
        den_q[s+1]  <= den_q[s];
        side_q[s+1] <= side_q[s];
        sat_q[s+1]  <= sat_q[s];
      end
    end
  end

  assign valid_o = vld_q[Q_W];
  assign quo_o   = sat_q[Q_W] ? '1 : quo_q[Q_W];
  assign side_o  = side_q[Q_W];

endmodule

@@ sv/wall_column_projection_core.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    perp_distance, hit_face, dir_x, dir_y
// out       output     out_valid_o / out_ready_i  slice_height, row_start, row_end,
//                                                 texel_column, texel_step, texel_start
// cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One transaction in and one out per cycle unless the output stalls; results pass through
// the column unit, two one-bit-per-stage dividers (16 and 26 stages), row and product stages.
// The whole pipeline advances together; it stalls only while a result waits at the output.
// Reset clears the stage valid bits and loads the register defaults.

module wall_column_projection_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic        [wcp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [wcp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic        [wcp_pkg::DIST_W-1:0]     perp_distance_i,
  input  logic                                  hit_face_i,
  input  logic signed [wcp_pkg::DIR_W-1:0]      dir_x_i,
  input  logic signed [wcp_pkg::DIR_W-1:0]      dir_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic        [wcp_pkg::HEIGHT_W-1:0]   slice_height_o,
  output logic        [wcp_pkg::ROW_W-1:0]      row_start_o,
  output logic        [wcp_pkg::ROW_W-1:0]      row_end_o,
  output logic        [wcp_pkg::COL_W-1:0]      texel_column_o,
  output logic        [wcp_pkg::STEP_W-1:0]     texel_step_o,
  output logic        [wcp_pkg::STEP_W-1:0]     texel_start_o
);

  localparam int unsigned HW    = wcp_pkg::HEIGHT_W;
  localparam int unsigned SIDE2 = HW + 3 * wcp_pkg::ROW_W + wcp_pkg::SKIP_W;
  localparam int unsigned NUM2  = wcp_pkg::TEX_W + wcp_pkg::FRAC_BITS;
  localparam int unsigned MUL_W = wcp_pkg::SKIP_W + wcp_pkg::STEP_W;
  localparam logic [HW-1:0] HALF = HW'(wcp_pkg::HALF_ROWS);
  localparam logic [HW-1:0] LAST = HW'(wcp_pkg::SCREEN_ROWS - 1);

  logic adv;

  logic [wcp_pkg::SCALE_W-1:0] height_scale_q;
  logic [wcp_pkg::TEX_W-1:0]   tex_width_q, tex_height_q;
  logic [wcp_pkg::POS_W-1:0]   viewer_x_q, viewer_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_scale_q <= wcp_pkg::SCALE_W'(3145728);
      tex_width_q    <= wcp_pkg::TEX_W'(64);
      tex_height_q   <= wcp_pkg::TEX_W'(64);
      viewer_x_q     <= '0;
      viewer_y_q     <= '0;
    end else if (cfg_we_i) begin
      case (wcp_pkg::cfg_reg_e'(cfg_index_i))
        wcp_pkg::CFG_HEIGHT_SCALE: height_scale_q <= cfg_data_i;
        wcp_pkg::CFG_TEX_WIDTH:    tex_width_q    <= cfg_data_i[wcp_pkg::TEX_W-1:0];
        wcp_pkg::CFG_TEX_HEIGHT:   tex_height_q   <= cfg_data_i[wcp_pkg::TEX_W-1:0];
        wcp_pkg::CFG_VIEWER_X:     viewer_x_q     <= cfg_data_i;
        wcp_pkg::CFG_VIEWER_Y:     viewer_y_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // column unit
  logic                          col_vld;
  logic [wcp_pkg::DIST_W-1:0]    col_dist;
  logic [wcp_pkg::COL_W-1:0]     col_val;

  wcp_tex_col u_tex_col (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .valid_i     (in_valid_i),
    .dist_i      (perp_distance_i),
    .face_i      (hit_face_i),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .viewer_x_i  (viewer_x_q),
    .viewer_y_i  (viewer_y_q),
    .tex_width_i (tex_width_q),
    .valid_o     (col_vld),
    .dist_o      (col_dist),
    .col_o       (col_val)
  );

  // slice height
  logic                          h_vld;
  logic [HW-1:0]                 h_val;
  logic [wcp_pkg::COL_W-1:0]     h_col;

  wcp_div_pipe #(
    .NUM_W  (wcp_pkg::SCALE_W),
    .DEN_W  (wcp_pkg::DIST_W),
    .Q_W    (HW),
    .SIDE_W (wcp_pkg::COL_W)
  ) u_height_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (col_vld),
    .num_i   (height_scale_q),
    .den_i   (col_dist),
    .side_i  (col_val),
    .valid_o (h_vld),
    .quo_o   (h_val),
    .side_o  (h_col)
  );

  // row span
  logic [HW-1:0]                 hh;
  logic [HW-1:0]                 re_full;
  logic                          rows_vld_q;
  logic [HW-1:0]                 rows_h_q;
  logic [wcp_pkg::ROW_W-1:0]     rs_d, rs_q, re_q;
  logic [wcp_pkg::SKIP_W-1:0]    skip_d, skip_q;
  logic [wcp_pkg::COL_W-1:0]     rows_col_q;

  always_comb begin
    hh      = h_val >> 1;
    rs_d    = (hh >= HALF) ? '0 : wcp_pkg::ROW_W'(HALF - hh);
    re_full = hh + HALF;
    if (re_full >= HW'(wcp_pkg::SCREEN_ROWS)) begin
      re_full = LAST;
    end
    skip_d  = (hh > HALF) ? wcp_pkg::SKIP_W'(hh - HALF) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_vld_q <= 1'b0;
    end else if (adv) begin
      rows_vld_q <= h_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rows_h_q   <= h_val;
      rs_q       <= rs_d;
      re_q       <= re_full[wcp_pkg::ROW_W-1:0];
      skip_q     <= skip_d;
      rows_col_q <= h_col;
    end
  end

  // texture step
  logic                          st_vld;
  logic [wcp_pkg::STEP_W-1:0]    st_val;
  logic [SIDE2-1:0]              st_side;

  wcp_div_pipe #(
    .NUM_W  (NUM2),
    .DEN_W  (HW),
    .Q_W    (wcp_pkg::STEP_W),
    .SIDE_W (SIDE2)
  ) u_step_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (rows_vld_q),
    .num_i   ({tex_height_q, wcp_pkg::FRAC_BITS'(0)}),
    .den_i   (rows_h_q),
    .side_i  ({rows_h_q, rs_q, re_q, rows_col_q, skip_q}),
    .valid_o (st_vld),
    .quo_o   (st_val),
    .side_o  (st_side)
  );

  // starting texture row
  logic                          mul_vld_q;
  logic [MUL_W-1:0]              mul_q;
  logic [wcp_pkg::STEP_W-1:0]    mul_step_q;
  logic [SIDE2-1:0]              mul_side_q;
  logic [wcp_pkg::SKIP_W-1:0]    st_skip;

  assign st_skip = st_side[wcp_pkg::SKIP_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      mul_vld_q   <= st_vld;
      out_valid_o <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_q          <= MUL_W'(st_skip) * MUL_W'(st_val);
      mul_step_q     <= st_val;
      mul_side_q     <= st_side;
      texel_start_o  <= (mul_q > MUL_W'(wcp_pkg::STEP_MAX))
                        ? wcp_pkg::STEP_MAX : mul_q[wcp_pkg::STEP_W-1:0];
      texel_step_o   <= mul_step_q;
      slice_height_o <= mul_side_q[SIDE2-1 -: HW];
      row_start_o    <= mul_side_q[SIDE2-HW-1 -: wcp_pkg::ROW_W];
      row_end_o      <= mul_side_q[SIDE2-HW-wcp_pkg::ROW_W-1 -: wcp_pkg::ROW_W];
      texel_column_o <= mul_side_q[wcp_pkg::SKIP_W +: wcp_pkg::COL_W];
    end
  end

  // advance the whole pipeline unless a result is held at the output
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (row_start_o <= row_end_o))
    else $error("row_start beyond row_end");

  a_zero_height_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && slice_height_o == '0) |-> (texel_step_o == wcp_pkg::STEP_MAX))
    else $error("zero height without saturated step");

  a_short_slice_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (slice_height_o >> 1) <= HALF) |-> (texel_start_o == '0))
    else $error("unclipped slice with nonzero texture start");

endmodule
